// ===== hw/rtl/alid_pkg.sv =====
// Package for the ordered byte list: depth, field widths, opcodes and the
// packed command and result item types. No dependencies.

package alid_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_APPEND      = 2'd0,
        MODE_INSERT      = 2'd1,
        MODE_DELETE      = 2'd2,
        MODE_DELETE_LAST = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [IDX_W-1:0] position;
        logic [7:0]       value;
    } cmd_item_t;

    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] length;
        logic [IDX_W-1:0] index;
        logic [7:0]       element;
        logic             element_valid;
        logic             last;
    } res_item_t;

endpackage

// ===== hw/rtl/array_list_insert_delete.sv =====
// Ordered byte list with append, insert, delete and delete-last operations.
// Steps: decode; shift (read, write per element moved); write of the new byte or
//   the cleared tail cell (a delete first checks its byte); read and load per result.
// Throughput: one item at a time; cmd_stall is high while busy.
// Reset: clears control, fill count and the result valid flag; list memory
//   contents are not cleared since only written entries are ever used.

module array_list_insert_delete (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  alid_pkg::cmd_item_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output alid_pkg::res_item_t res
);
    import alid_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DECIDE    = 11'b000_0000_0010,
        S_INS_RD    = 11'b000_0000_0100,
        S_INS_WR    = 11'b000_0000_1000,
        S_INS_PUT   = 11'b000_0001_0000,
        S_DEL_CHK   = 11'b000_0010_0000,
        S_DEL_RD    = 11'b000_0100_0000,
        S_DEL_WR    = 11'b000_1000_0000,
        S_DEL_CLR   = 11'b001_0000_0000,
        S_EMIT_RD   = 11'b010_0000_0000,
        S_EMIT_LOAD = 11'b100_0000_0000
    } state_t;

    // sequencer state
    state_t           state_reg, state_next;
    mode_t            mode_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [7:0]       val_reg;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ok_reg, ok_next;
    logic             res_valid_reg, res_valid_next;
    res_item_t        res_reg, res_next;

    // list memory: one write port, one registered read port
    logic [7:0]       mem [DEPTH];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data_reg;

    logic             cmd_take;
    logic             full;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] idx_ext;
    logic             emit_last;
    logic             res_free;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign full      = (fill_reg == LEN_W'(DEPTH));
    assign pos_ext   = {1'b0, pos_reg};
    assign idx_ext   = {1'b0, idx_reg};
    assign emit_last = (fill_reg == '0) || (idx_ext + LEN_W'(1) == fill_reg);
    assign res_free  = !res_valid_reg || !res_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        ok_next        = ok_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // default outcome: rejected, emit contents unchanged
                ok_next    = 1'b0;
                idx_next   = '0;
                state_next = S_EMIT_RD;
                case (mode_reg)
                    MODE_APPEND:
                    begin
                        if (!full)
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = fill_reg[IDX_W-1:0];
                            wr_data   = val_reg;
                            fill_next = fill_reg + LEN_W'(1);
                            ok_next   = 1'b1;
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (!full && pos_ext <= fill_reg)
                        begin
                            if (pos_ext == fill_reg)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = pos_reg;
                                wr_data   = val_reg;
                                fill_next = fill_reg + LEN_W'(1);
                                ok_next   = 1'b1;
                            end
                            else
                            begin
                                // shift right from the end down to position
                                idx_next   = fill_reg[IDX_W-1:0];
                                state_next = S_INS_RD;
                            end
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (pos_ext < fill_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_reg;
                            idx_next   = pos_reg;
                            state_next = S_DEL_CHK;
                        end
                    end
                    MODE_DELETE_LAST:
                    begin
                        if (fill_reg != '0)
                        begin
                            state_next = S_DEL_CLR;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT_RD;
                    end
                endcase
            end

            S_INS_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg - IDX_W'(1);
                state_next = S_INS_WR;
            end

            S_INS_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                idx_next = idx_reg - IDX_W'(1);
                if (idx_reg - IDX_W'(1) == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end

            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                fill_next  = fill_reg + LEN_W'(1);
                ok_next    = 1'b1;
                idx_next   = '0;
                state_next = S_EMIT_RD;
            end

            S_DEL_CHK:
            begin
                // a zero byte at the position rejects the delete
                if (rd_data_reg == 8'd0)
                begin
                    ok_next    = 1'b0;
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
                else if (pos_ext + LEN_W'(1) < fill_reg)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    state_next = S_DEL_CLR;
                end
            end

            S_DEL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg + IDX_W'(1);
                state_next = S_DEL_WR;
            end

            S_DEL_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_ext + LEN_W'(2) < fill_reg)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    state_next = S_DEL_CLR;
                end
            end

            S_DEL_CLR:
            begin
                // clear the vacated tail cell and shrink
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(fill_reg - LEN_W'(1));
                wr_data    = 8'd0;
                fill_next  = fill_reg - LEN_W'(1);
                ok_next    = 1'b1;
                idx_next   = '0;
                state_next = S_EMIT_RD;
            end

            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_EMIT_LOAD;
            end

            S_EMIT_LOAD:
            begin
                if (res_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.ok            = ok_reg;
                    res_next.length        = fill_reg;
                    res_next.index         = idx_reg;
                    res_next.element_valid = (fill_reg != '0);
                    res_next.element       = (fill_reg != '0) ? rd_data_reg : 8'd0;
                    res_next.last          = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            ok_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            ok_reg        <= ok_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            mode_reg <= cmd.mode;
            pos_reg  <= cmd.position;
            val_reg  <= cmd.value;
        end
        res_reg <= res_next;
    end

endmodule

// ===== tb/array_list_insert_delete_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ordered byte list: watches both channels, keeps a shadow list,
// predicts every result item and compares field by field. Uses alid_pkg.

module array_list_insert_delete_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  logic                       cmd_stall,
    input  alid_pkg::cmd_item_t        cmd,
    input  logic                       res_valid,
    input  logic                       res_stall,
    input  alid_pkg::res_item_t        res,
    output int                         errors,
    output int                         results_due,
    output logic [alid_pkg::LEN_W-1:0] fill_now
);
    import alid_pkg::*;

    logic [7:0] shadow_list [DEPTH];
    int         shadow_fill;
    res_item_t  contents_q [$];

    // Apply one command to the shadow list, then queue the contents dump it causes.
    task automatic apply_cmd(input cmd_item_t c);
        logic      done;
        res_item_t r;
        int        i;
        done = 1'b0;
        case (c.mode)
            MODE_APPEND:
                if (shadow_fill < DEPTH)
                begin
                    shadow_list[shadow_fill] = c.value;
                    shadow_fill++;
                    done = 1'b1;
                end
            MODE_INSERT:
                if (shadow_fill < DEPTH && int'(c.position) <= shadow_fill)
                begin
                    for (i = shadow_fill; i > int'(c.position); i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[c.position] = c.value;
                    shadow_fill++;
                    done = 1'b1;
                end
            MODE_DELETE:
                if (int'(c.position) < shadow_fill && shadow_list[c.position] != 8'd0)
                begin
                    for (i = int'(c.position); i + 1 < shadow_fill; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_list[shadow_fill - 1] = 8'd0;
                    shadow_fill--;
                    done = 1'b1;
                end
            MODE_DELETE_LAST:
                if (shadow_fill > 0)
                begin
                    shadow_list[shadow_fill - 1] = 8'd0;
                    shadow_fill--;
                    done = 1'b1;
                end
            default:
            begin
                done = 1'b0;
            end
        endcase

        if (shadow_fill == 0)
        begin
            r      = '0;
            r.ok   = done;
            r.last = 1'b1;
            contents_q.push_back(r);
        end
        else
        begin
            for (i = 0; i < shadow_fill; i++)
            begin
                r.ok            = done;
                r.length        = shadow_fill[LEN_W-1:0];
                r.index         = i[IDX_W-1:0];
                r.element       = shadow_list[i];
                r.element_valid = 1'b1;
                r.last          = (i == shadow_fill - 1);
                contents_q.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v, inout int bad);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            bad++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int        bad;
        int        i;
        res_item_t want;
        if (!rst_n)
        begin
            for (i = 0; i < DEPTH; i++)
                shadow_list[i] = 8'd0;
            shadow_fill = 0;
            contents_q.delete();
            errors      <= 0;
            results_due <= 0;
            fill_now    <= '0;
        end
        else
        begin
            bad = 0;
            // results first: an item taken at this edge cannot have produced one yet
            if (res_valid && !res_stall)
            begin
                if (contents_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none got %p", $time, res);
                    bad++;
                end
                else
                begin
                    want = contents_q.pop_front();
                    check_field("ok", 8'(want.ok), 8'(res.ok), bad);
                    check_field("length", 8'(want.length), 8'(res.length), bad);
                    check_field("index", 8'(want.index), 8'(res.index), bad);
                    check_field("element", want.element, res.element, bad);
                    check_field("element_valid", 8'(want.element_valid),
                                8'(res.element_valid), bad);
                    check_field("last", 8'(want.last), 8'(res.last), bad);
                end
            end
            if (cmd_valid && !cmd_stall)
                apply_cmd(cmd);
            errors      <= errors + bad;
            results_due <= contents_q.size();
            fill_now    <= shadow_fill[LEN_W-1:0];
        end
    end

endmodule

// ===== tb/array_list_insert_delete_tb.sv =====
`timescale 1ns / 100ps
// Top of the ordered byte list testbench: clock, reset, command stimulus, output
// stall patterns and the verdict. Needs alid_pkg, the block and its checker.

module array_list_insert_delete_tb;
    import alid_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;          // cycles with no item moving
    localparam int HOLD_CYCLES    = 300;           // long output hold-off
    localparam int DRAIN_CYCLES   = 4 * DEPTH + 8; // extra wait after the final drain

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    cmd_item_t        cmd       = '0;
    logic             res_valid;
    logic             res_stall = 1'b1;
    res_item_t        res;

    int               errors;
    int               results_due;
    logic [LEN_W-1:0] fill_now;

    // idle percentages: the sender's is used only by the stimulus process
    int               tx_idle   = 35;
    int               rx_idle   = 81;

    logic             hold_req  = 1'b0;
    logic             hold_armed = 1'b0;
    int               hold_left = 0;

    int               quiet_cycles = 0;
    int               sent      = 0;
    int               rand_k    = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    array_list_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    array_list_insert_delete_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .errors      (errors),
        .results_due (results_due),
        .fill_now    (fill_now)
    );

    // Receiver. A rising hold_req starts one long hold-off, counted here; otherwise
    // the stall is random at the current rate.
    always @(posedge clk)
    begin
        if (hold_req && !hold_armed)
        begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            res_stall  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(0, 99) < rx_idle);
        if (!hold_req)
            hold_armed <= 1'b0;
    end

    // Watchdog: any accepted item on either side counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic cmd_item_t mk(input mode_t m, input int p, input int v);
        cmd_item_t c;
        c.mode     = m;
        c.position = IDX_W'(p);
        c.value    = 8'(v);
        return c;
    endfunction

    // Bytes: mostly nonzero so deletes get through, with zero and all-ones sprinkled in.
    function automatic logic [7:0] pick_value();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(1, 254));
    endfunction

    // Random command biased toward growing or shrinking the list. Positions follow
    // the checker's fill count, which may trail by one item; the few rejects that
    // causes are welcome. About one in twelve is pure noise.
    function automatic cmd_item_t next_cmd(input logic grow);
        cmd_item_t c;
        int        len;
        int        r;
        len        = int'(fill_now);
        r          = $urandom_range(0, 99);
        c.value    = pick_value();
        c.position = '0;
        if (r >= 92)
        begin
            c.mode     = mode_t'($urandom_range(0, 3));
            c.position = IDX_W'($urandom_range(0, DEPTH - 1));
        end
        else if (grow ? r < 50 : r < 10)
            c.mode = MODE_APPEND;
        else if (grow ? r < 80 : r < 20)
        begin
            c.mode     = MODE_INSERT;
            c.position = IDX_W'($urandom_range(0, len < DEPTH ? len : DEPTH - 1));
        end
        else if (grow ? r < 88 : r < 65)
        begin
            c.mode     = MODE_DELETE;
            c.position = IDX_W'($urandom_range(0, len > 0 ? len - 1 : 0));
        end
        else
            c.mode = MODE_DELETE_LAST;
        return c;
    endfunction

    // Offer one command. Valid drops only for random idle cycles before the item,
    // never in the step it gets raised again. The stall is looked at on the falling
    // edge, so the rising edge that follows is the one that takes the item.
    task automatic send_cmd(input cmd_item_t c);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(negedge clk);
        while (cmd_stall);
        @(posedge clk);
        sent++;
    endtask

    // Sender goes quiet until every predicted result item has come out.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        @(posedge clk);
    endtask

    // Shrink and grow runs of 16 items alternate, carried across phases.
    task automatic run_random(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            send_cmd(next_cmd(((rand_k / 16) % 2) == 1));
            rand_k++;
        end
    endtask

    initial
    begin
        int n;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: empty list corner cases, then small-list inserts and deletes
        send_cmd(mk(MODE_DELETE, 0, 8'h00));        // delete on empty
        send_cmd(mk(MODE_DELETE_LAST, 0, 8'h00));   // delete last on empty
        send_cmd(mk(MODE_INSERT, 1, 8'h42));        // insert past the end
        send_cmd(mk(MODE_INSERT, 0, 8'hFF));        // insert at end of empty list
        send_cmd(mk(MODE_APPEND, 0, 8'h00));        // a stored zero byte
        send_cmd(mk(MODE_INSERT, 2, 8'h80));        // insert at end acts as append
        send_cmd(mk(MODE_INSERT, 1, 8'h01));        // insert in the middle, shift right
        send_cmd(mk(MODE_DELETE, 2, 8'h00));        // zero byte there: rejected
        send_cmd(mk(MODE_DELETE, 0, 8'h00));        // delete the head, shift left
        // fill up to DEPTH
        for (n = 0; n < 13; n++)
            send_cmd(mk(MODE_APPEND, 0, 16 + n * 19));
        send_cmd(mk(MODE_APPEND, 0, 8'h55));        // full: rejected
        send_cmd(mk(MODE_INSERT, 0, 8'hAA));        // full: rejected
        send_cmd(mk(MODE_DELETE, 15, 8'h00));       // delete at the top index
        send_cmd(mk(MODE_DELETE, 15, 8'h00));       // now out of range
        send_cmd(mk(MODE_INSERT, 15, 8'hC3));       // insert at end, all-ones position
        wait_drained();

        // --- random, phase one: sender idles sometimes, receiver mostly stalls
        run_random(25);

        // --- phase two: roles swapped
        tx_idle = 81;
        rx_idle <= 35;
        run_random(25);
        wait_drained();

        // --- phase three: no idling on either side, opened by a long output hold
        // while commands keep coming, so the block backs up and stalls its input
        tx_idle = 0;
        rx_idle <= 0;
        hold_req <= 1'b1;
        run_random(25);
        hold_req <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d list commands: empty and full corner cases,", sent);
        $display("grow and shrink sequences, three stall mixes and a long output hold.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
